@@ rtl/columnar_transposition_cipher_macros.svh @@
// ---------------------------------------------------------------------------
// Columnar transposition cipher: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef COLUMNAR_TRANSPOSITION_CIPHER_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_CIPHER_MACROS_SVH

// Same-cycle implication.
`define CTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ctc_pkg.sv @@
// ---------------------------------------------------------------------------
// Columnar transposition cipher package
// Transaction types, FSM states, register map and shared constants.
// ---------------------------------------------------------------------------
package ctc_pkg;

  localparam int KEY_W   = 6;   // columns register, grid limits, item index
  localparam int POS_W   = 11;  // linear grid position, up to 63 * 32
  localparam int KEEP_W  = 7;   // kept length after stripping, up to 64
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [7:0]        PAD_BYTE     = 8'h78;
  localparam logic [KEY_W-1:0]  SCAN_LAST_K  = 6'd63;  // 64 grid cells at most
  localparam logic [KEY_W-1:0]  EMIT_LAST_K  = 6'd62;  // 63 results at most
  localparam logic [KEEP_W-1:0] KEEP_FULL    = 7'd64;
  localparam logic [KEEP_W-1:0] KEEP_CAP     = 7'd63;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_MODE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       empty_result;
    logic       overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_CHK
  } state_t;

  typedef struct packed {
    logic restart;
    logic advance;
  } iter_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] inner_lim;
    logic [KEY_W-1:0] outer_lim;
    logic [KEY_W-1:0] stride;
  } iter_geom_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] k;
    logic             grid_last;
  } iter_stat_t;

endpackage

@@ rtl/ctc_grid_iter.sv @@
// ---------------------------------------------------------------------------
// Grid walker
// Steps through a grid in inner/outer order and keeps the linear position.
// ---------------------------------------------------------------------------
module ctc_grid_iter
  import ctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  iter_cmd_t  cmd,
  input  iter_geom_t geom,
  output iter_stat_t stat
);

  logic [KEY_W-1:0] inner;
  logic [KEY_W-1:0] outer;
  logic [POS_W-1:0] pos;
  logic [KEY_W-1:0] k;
  logic             inner_end;

  // The position advances by the stride along the inner loop and restarts
  // at the outer index, so no multiplier is needed.
  assign inner_end = (inner == geom.inner_lim - KEY_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      inner <= '0;
      outer <= '0;
      pos   <= '0;
      k     <= '0;
    end else if (cmd.advance) begin
      k <= k + KEY_W'(1);
      if (inner_end) begin
        inner <= '0;
        outer <= outer + KEY_W'(1);
        pos   <= POS_W'(outer) + POS_W'(1);
      end else begin
        inner <= inner + KEY_W'(1);
        pos   <= pos + POS_W'(geom.stride);
      end
    end
  end

  assign stat.pos       = pos;
  assign stat.k         = k;
  assign stat.grid_last = inner_end && (outer == geom.outer_lim - KEY_W'(1));

endmodule

@@ rtl/columnar_transposition_cipher.sv @@
// ---------------------------------------------------------------------------
// Columnar transposition cipher
// Buffers one message in a byte memory and replays it in transposed order.
// ---------------------------------------------------------------------------
// Usage:
// Message bytes arrive as input transactions (in_valid/in_stall/in_data).
// Each byte is written into the message memory; the byte that carries
// in_last closes the message and starts emission, during which in_stall
// stays high. Bytes beyond MAX_LEN are dropped and every result of
// that message then reports overflow.
// Emission first derives the row count by repeated subtraction of the key.
// In decrypt mode a scan pass then reads every grid cell (at most 64 cells)
// to find where trailing pad bytes begin. Each result then takes a read
// step and a use step on the single memory read port, so the walk fetches
// the next byte only once the current result has been loaded into the
// output register, which decouples the two sides: when out_stall is high
// the walk waits on the pending result, and after the final result is
// registered the next message may load while it is still waiting.
// Reset clears the byte count, overflow flag, output valid and the
// registers (columns = 1, mode = encrypt). The memory needs no clearing.
// ---------------------------------------------------------------------------
module columnar_transposition_cipher
  import ctc_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  // Message byte transactions.
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // Result transactions.
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

`include "columnar_transposition_cipher_macros.svh"

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  // Configuration registers.
  logic [KEY_W-1:0] columns;
  logic             mode;
  logic [KEY_W-1:0] key;
  reg_idx_t         reg_idx;

  // Message state.
  logic [7:0]       mem [MAX_LEN];
  logic [7:0]       rdata;
  logic             in_rng;
  logic [CW-1:0]    byte_count;
  logic             overflow_seen;
  logic             room;
  logic             in_take;

  // Row count division and strip tracking.
  logic [KEY_W-1:0]  rows;
  logic [KEY_W-1:0]  rem;
  logic [KEEP_W-1:0] keep_n;
  logic [KEEP_W-1:0] keep_lim;
  logic              decrypt;

  // Control.
  state_t     state;
  state_t     state_next;
  iter_cmd_t  iter_cmd;
  iter_geom_t iter_geom;
  iter_stat_t iter_stat;
  logic [7:0] cell_byte;
  logic       out_free;
  logic       out_load;
  out_item_t  out_next;
  logic       scan_keep;

  // -------------------------------------------------------------------------
  // Register port: writes land on the access phase; reads are always ready.
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= KEY_W'(1);
      mode    <= MODE_ENCRYPT;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_COLUMNS: columns <= pwdata[KEY_W-1:0];
        REG_MODE:    mode    <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLUMNS: prdata = DATA_W'(columns);
      REG_MODE:    prdata = DATA_W'(mode);
      default:     prdata = '0;
    endcase
  end

  // A key of zero behaves as a single column.
  assign key     = (columns == '0) ? KEY_W'(1) : columns;
  assign decrypt = (mode == MODE_DECRYPT);

  // -------------------------------------------------------------------------
  // Message memory: one write port for loading, one registered read port.
  // -------------------------------------------------------------------------
  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign room     = (byte_count < CW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (in_take && room) begin
      mem[byte_count[AW-1:0]] <= in_data.in_byte;
    end
    rdata  <= mem[iter_stat.pos[AW-1:0]];
    in_rng <= (iter_stat.pos < POS_W'(byte_count));
  end

  // Cells past the message end read as the pad byte.
  assign cell_byte = in_rng ? rdata : PAD_BYTE;

  // -------------------------------------------------------------------------
  // Grid walk. Encrypt runs columns outside and rows inside with a stride of
  // the key; decrypt runs rows outside and columns inside with a stride of
  // the row count.
  // -------------------------------------------------------------------------
  assign iter_geom.inner_lim = decrypt ? key  : rows;
  assign iter_geom.outer_lim = decrypt ? rows : key;
  assign iter_geom.stride    = decrypt ? rows : key;

  ctc_grid_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .cmd  (iter_cmd),
    .geom (iter_geom),
    .stat (iter_stat)
  );

  // Decrypt emits up to the last non-pad cell, never more than 63 results.
  assign keep_lim  = (keep_n == KEEP_FULL) ? KEEP_CAP : keep_n;
  assign scan_keep = (cell_byte != PAD_BYTE);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_cmd   = '0;
    out_load   = 1'b0;

    out_next.empty_result = decrypt && (keep_n == '0);
    out_next.out_byte     = out_next.empty_result ? 8'h00 : cell_byte;
    out_next.overflow     = overflow_seen;
    if (out_next.empty_result) begin
      out_next.out_last = 1'b1;
    end else if (decrypt) begin
      out_next.out_last = (KEEP_W'(iter_stat.k) + KEEP_W'(1) == keep_lim);
    end else begin
      out_next.out_last = iter_stat.grid_last || (iter_stat.k == EMIT_LAST_K);
    end

    unique case (state)
      ST_LOAD: begin
        if (in_take && in_data.in_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem <= key) begin
          iter_cmd.restart = 1'b1;
          state_next = decrypt ? ST_SCAN_RD : ST_EMIT_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (iter_stat.grid_last || (iter_stat.k == SCAN_LAST_K)) begin
          iter_cmd.restart = 1'b1;
          state_next = ST_EMIT_RD;
        end else begin
          iter_cmd.advance = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_CHK;
      end
      ST_EMIT_CHK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (out_next.out_last) begin
            state_next = ST_LOAD;
          end else begin
            iter_cmd.advance = 1'b1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // -------------------------------------------------------------------------
  // Byte count, overflow flag, row count and strip point.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (out_load && out_next.out_last) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (in_take) begin
      if (room) begin
        byte_count <= byte_count + CW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Rows are ceil(len / key): count subtractions until the rest fits a row.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      rows   <= '0;
      keep_n <= '0;
      rem    <= room ? KEY_W'(byte_count) + KEY_W'(1) : KEY_W'(byte_count);
    end else if (state == ST_DIV) begin
      rows <= rows + KEY_W'(1);
      if (rem > key) begin
        rem <= rem - key;
      end
    end else if (state == ST_SCAN_CHK && scan_keep) begin
      keep_n <= KEEP_W'(iter_stat.k) + KEEP_W'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Output register.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `CTC_ASSERT_IMP(a_count_bound, 1'b1, byte_count <= CW'(MAX_LEN), "byte count above capacity")
  `CTC_ASSERT_NXT(a_last_starts_div, in_take && in_data.in_last, state == ST_DIV, "last byte did not start emission")
  `CTC_ASSERT_NXT(a_last_clears, out_load && out_next.out_last, state == ST_LOAD && byte_count == '0 && !overflow_seen, "message state not cleared after final result")
  `CTC_ASSERT_IMP(a_rows_nonzero, state == ST_EMIT_CHK || state == ST_SCAN_CHK, rows != '0, "grid walk with zero rows")

endmodule

@@ sim/columnar_transposition_cipher_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Columnar transposition cipher testbench
// Drives message bytes and register writes into the cipher, predicts every
// result byte with an independent grid transposition and compares each
// result transaction field by field, under random stalls on both sides.
// ---------------------------------------------------------------------------
module columnar_transposition_cipher_tb
  import ctc_pkg::*;
;

  localparam int MSG_CAP    = 32;  // bytes the block keeps per message
  localparam int SETTLE     = 8;   // quiet cycles before a register write
  localparam int RAND_BYTES = 10;

  // Clock and reset. Every input holds a known value from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  always #2 clk = ~clk;

  columnar_transposition_cipher #(
    .MAX_LEN(MSG_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: our own copy of the message buffer and the registers.
  logic [7:0]       stored_bytes [MSG_CAP];
  int               stored_len       = 0;
  logic             overflow_pending = 1'b0;
  logic [KEY_W-1:0] key_columns      = 6'd1;
  logic             key_mode         = MODE_ENCRYPT;

  // Result bytes predicted but not yet seen on the output, oldest first.
  out_item_t pending_results [$];

  // Both sides idle at random only while this is set.
  logic idling_on = 1'b1;

  int mismatches    = 0;
  int bytes_sent    = 0;
  int messages_done = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int empty_seen    = 0;
  int overflow_seen = 0;

  // A grid cell reads the stored byte if the position lies inside the
  // message, otherwise the pad character.
  function automatic logic [7:0] grid_cell(int pos, int len);
    if (pos < len && pos < MSG_CAP) return stored_bytes[pos];
    return PAD_BYTE;
  endfunction

  // Account for one accepted message byte. A byte without the last flag only
  // fills the buffer; the last byte lays out the grid and queues every
  // result transaction the block must produce for the message.
  function automatic void record_byte(in_item_t item);
    int         len;
    int         key;
    int         rows;
    int         total;
    int         n;
    logic [7:0] seq [64];
    logic       ovf;
    out_item_t  res;
    if (stored_len < MSG_CAP) begin
      stored_bytes[stored_len] = item.in_byte;
      stored_len++;
    end else begin
      overflow_pending = 1'b1;
    end
    if (!item.in_last) return;

    len   = stored_len;
    key   = (key_columns == 0) ? 1 : int'(key_columns);
    rows  = (len + key - 1) / key;
    total = rows * key;
    if (total > 64) total = 64;
    n = 0;
    if (key_mode == MODE_ENCRYPT) begin
      // Written row by row, read column by column.
      for (int col = 0; col < key; col++)
        for (int row = 0; row < rows; row++)
          if (n < total) begin
            seq[n] = grid_cell(row * key + col, len);
            n++;
          end
    end else begin
      // Written column by column, read row by row, pad tail removed.
      for (int row = 0; row < rows; row++)
        for (int col = 0; col < key; col++)
          if (n < total) begin
            seq[n] = grid_cell(col * rows + row, len);
            n++;
          end
      while (n > 0 && seq[n-1] == PAD_BYTE) n--;
    end

    ovf              = overflow_pending;
    stored_len       = 0;
    overflow_pending = 1'b0;
    messages_done++;

    if (n == 0) begin
      // Everything was stripped: a single empty marker closes the message.
      res = '{out_byte: 8'h00, out_last: 1'b1, empty_result: 1'b1, overflow: ovf};
      pending_results.push_back(res);
      return;
    end
    if (n > 63) n = 63;
    for (int k = 0; k < n; k++) begin
      res = '{out_byte: seq[k], out_last: (k == n - 1), empty_result: 1'b0,
              overflow: ovf};
      pending_results.push_back(res);
    end
  endfunction

  // Result checker. The block updates its outputs with nonblocking
  // assignments, so the values read here are those present before the edge.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: out_byte %h", out_data.out_byte);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.empty_result) empty_seen++;
        if (want.overflow) overflow_seen++;
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          mismatches++;
        end
        if (out_data.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
          mismatches++;
        end
        if (out_data.empty_result !== want.empty_result) begin
          $error("empty_result: expected %b, got %b", want.empty_result,
                 out_data.empty_result);
          mismatches++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_data.overflow);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts.
  always begin : result_stall
    @(posedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Offer one message byte and hold it until the block takes it. The valid
  // stays high on return; whoever pauses next is responsible for lowering it
  // in the same time step, so the next byte can follow without a bubble.
  task automatic send_byte(logic [7:0] value, logic last);
    in_item_t item;
    item = '{in_byte: value, in_last: last};
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    record_byte(item);
    bytes_sent++;
  endtask

  // A message of random bytes; pad_pct sets how often the pad character is
  // picked, which is what drives the stripping logic in decrypt mode.
  task automatic send_message(int len, int pad_pct);
    logic [7:0] value;
    for (int i = 0; i < len; i++) begin
      value = ($urandom_range(0, 99) < pad_pct) ? PAD_BYTE : 8'($urandom_range(0, 255));
      send_byte(value, i == len - 1);
    end
  endtask

  // Stop sending and wait until every predicted result has come out, then
  // leave a few more cycles for the block to settle back into loading.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes
  // at the edge where pready is seen high.
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COLUMNS: key_columns = value[KEY_W-1:0];
      REG_MODE:    key_mode    = value[0];
      default:     ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // New key and mode, written only once the block has gone idle.
  task automatic set_config(logic [KEY_W-1:0] cols, logic mode);
    wait_idle();
    write_reg(REG_COLUMNS, DATA_W'(cols));
    write_reg(REG_MODE, DATA_W'(mode));
    settings_used++;
  endtask

  // Reset values: one column in encrypt mode passes bytes straight through.
  // The two bytes cover every data bit at both levels.
  task automatic test_reset_passthrough();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // A five-byte message in a four-column grid leaves three pad cells in the
  // last row, all of which appear in the encrypted output.
  task automatic test_encrypt_grid();
    set_config(6'd4, MODE_ENCRYPT);
    send_byte("H", 1'b0);
    send_byte("E", 1'b0);
    send_byte("L", 1'b0);
    send_byte("L", 1'b0);
    send_byte("O", 1'b1);
  endtask

  // Decrypt with trailing pad bytes that must be stripped, then a message
  // made only of pad bytes, which collapses to the single empty marker.
  task automatic test_decrypt_strip();
    set_config(6'd4, MODE_DECRYPT);
    send_byte("A", 1'b0);
    send_byte(PAD_BYTE, 1'b0);
    send_byte("B", 1'b0);
    send_byte(PAD_BYTE, 1'b0);
    send_byte(PAD_BYTE, 1'b1);
    send_byte(PAD_BYTE, 1'b0);
    send_byte(PAD_BYTE, 1'b1);
  endtask

  // Key extremes: zero acts as one column, a key beyond the buffer size
  // gives a single row of mostly pad, and a key equal to the buffer size of 32.
  task automatic test_key_extremes();
    set_config(6'd0, MODE_DECRYPT);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    set_config(6'd63, MODE_ENCRYPT);
    send_byte("Z", 1'b1);
    set_config(6'd32, MODE_DECRYPT);
    send_byte("p", 1'b0);
    send_byte("q", 1'b0);
    send_byte("r", 1'b1);
  endtask

  // Messages at and past the buffer size: the excess is dropped, including a
  // last-marked byte, and every result of an overlong message carries the
  // overflow flag. The all-pad second message flags its empty marker too.
  task automatic test_capacity();
    set_config(6'd32, MODE_ENCRYPT);
    send_message(MSG_CAP + 2, 10);
    set_config(6'd1, MODE_DECRYPT);
    send_message(MSG_CAP + 1, 100);
    set_config(6'd5, MODE_ENCRYPT);
    send_message(MSG_CAP, 25);
  endtask

  // Random keys, modes and messages. Most messages are short; a few run
  // past the buffer. Every so often the sender waits for the block to drain
  // before it carries on with the same setting.
  task automatic test_random_messages();
    int               start_bytes;
    logic [KEY_W-1:0] cols;
    int               len;
    int               pad_pct;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RAND_BYTES) begin
      case ($urandom_range(0, 9))
        0:       cols = 6'd0;
        1:       cols = KEY_W'($urandom_range(33, 63));
        default: cols = KEY_W'($urandom_range(1, 32));
      endcase
      set_config(cols, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
        len     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 36) : $urandom_range(1, 10);
        pad_pct = ($urandom_range(0, 7) == 0) ? 100 : 25;
        send_message(len, pad_pct);
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
    end
  endtask

  // Closing stretch with no idling on either side, so messages and their
  // results run back to back at full rate.
  task automatic test_back_to_back();
    wait_idle();
    idling_on = 1'b0;
    set_config(6'd7, MODE_DECRYPT);
    repeat (2) send_message($urandom_range(3, 8), 25);
    set_config(6'd3, MODE_ENCRYPT);
    repeat (2) send_message($urandom_range(1, 6), 25);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_passthrough();
    test_encrypt_grid();
    test_decrypt_strip();
    test_key_extremes();
    test_capacity();
    test_random_messages();
    test_back_to_back();

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d messages over %0d key settings, checked %0d results.",
             bytes_sent, messages_done, settings_used, results_seen);
    $display("Empty markers checked: %0d, results flagged for overflow: %0d.",
             empty_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs or a result never arrives.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
